>>> src/scalar_to_rgb_colormap_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scalar-to-RGB colormap
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCALAR_TO_RGB_COLORMAP_ASSERT_SVH
`define SCALAR_TO_RGB_COLORMAP_ASSERT_SVH

// same-cycle implication
`define S2RGB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2rgb: same-cycle check failed");

// next-cycle implication
`define S2RGB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2rgb: next-cycle check failed");

`endif

>>> src/s2rgb_pkg.sv
// ----------------------------------------------------------------------------
// s2rgb_pkg
// Types and constants shared by the scalar-to-RGB colormap files.
// ----------------------------------------------------------------------------
`default_nettype none

package s2rgb_pkg;

    localparam int IN_W = 18;
    localparam int CH_W = 8;

    typedef enum logic [1:0] {
        MAP_HOT     = 2'd0,
        MAP_VIRIDIS = 2'd1,
        MAP_MAGMA   = 2'd2,
        MAP_GRAY    = 2'd3
    } map_t;

    // hot map: q = floor(8500*v/ONE) against 2805, q2 = floor(12750*v/ONE) against 8415
    localparam int Q_W      = 14;
    localparam int HOT_K1   = 8500;
    localparam int HOT_T33  = 2805;
    localparam int HOT_K2   = 12750;
    localparam int HOT_T66  = 8415;
    localparam int RECIP_SH = 20;
    localparam int RECIP11  = 95326;
    localparam int RECIP17  = 61681;
    localparam int P11_W    = Q_W + 17;
    localparam int P17_W    = Q_W + 16;

    localparam int MAG_R    = 252;
    localparam int MAG_G    = 180;
    localparam int MAG_B    = 40000;
    localparam int GRAY_K   = 255;

    localparam int VIR_N    = 5;
    localparam int VIR_IW   = 3;
    localparam logic [CH_W-1:0] VIR_PTS [VIR_N][3] = '{
        '{8'd68,  8'd1,   8'd84},
        '{8'd59,  8'd82,  8'd139},
        '{8'd33,  8'd145, 8'd140},
        '{8'd94,  8'd201, 8'd98},
        '{8'd253, 8'd231, 8'd37}
    };

    // integer square root, two radicand bits per step
    localparam int RAD_W  = 16;
    localparam int ROOT_W = 8;
    localparam int REM_W  = ROOT_W + 3;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } isq_t;

    function automatic isq_t isq_step(isq_t cur, logic [1:0] pair);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        isq_t             nxt;
        rem_sh = {cur.rem[REM_W-3:0], pair};
        trial  = {1'b0, cur.root, 2'b01};
        if (rem_sh >= trial)
        begin
            nxt.rem  = rem_sh - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = rem_sh;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

>>> src/s2rgb_in_if.sv
// ----------------------------------------------------------------------------
// s2rgb_in_if
// Intensity channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2rgb_in_if
    import s2rgb_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] intensity;

    modport source (output valid, output intensity, input ready);
    modport sink   (input valid, input intensity, output ready);
endinterface

`default_nettype wire

>>> src/s2rgb_out_if.sv
// ----------------------------------------------------------------------------
// s2rgb_out_if
// Pixel channel: valid/ready handshake with one 8-bit RGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2rgb_out_if
    import s2rgb_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> src/s2rgb_isqrt.sv
// ----------------------------------------------------------------------------
// s2rgb_isqrt
// Floor square root of a 16-bit value: four steps, a register, four steps.
// ----------------------------------------------------------------------------
`default_nettype none

module s2rgb_isqrt
    import s2rgb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic      [ROOT_W-1:0] root
);

    localparam int HALF_STEPS = ROOT_W / 2;
    localparam int LOW_W      = RAD_W / 2;

    isq_t             hi_next;
    isq_t             hi_reg;
    logic [LOW_W-1:0] low_reg;
    isq_t             lo_res;

    always_comb
    begin
        hi_next = '0;
        for (int i = 0; i < HALF_STEPS; i++)
        begin
            hi_next = isq_step(hi_next, radicand[RAD_W-1-2*i -: 2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg  <= hi_next;
            low_reg <= radicand[LOW_W-1:0];
        end
    end

    always_comb
    begin
        lo_res = hi_reg;
        for (int i = 0; i < HALF_STEPS; i++)
        begin
            lo_res = isq_step(lo_res, low_reg[LOW_W-1-2*i -: 2]);
        end
        root = lo_res.root;
    end

endmodule

`default_nettype wire

>>> src/scalar_to_rgb_colormap.sv
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap
// False-color map from one normalized intensity to an 8-bit RGB pixel.
// ----------------------------------------------------------------------------
// Usage:
//   sample : intensity in, signed fixed point, FRAC_BITS fraction bits,
//            clamped to 0..1 before mapping.
//   pixel  : red, green, blue out, one pixel per sample, in order.
//   cfg_wr_en / cfg_wr_data write the map select (hot, viridis, magma,
//   gray); write it only while no pixel is in flight.
//   A sample transfer reaches pixel.valid through the four-stage pipeline
//   (clamp, products, scaling and first square-root half, select and output
//   register); one sample per cycle is taken until a stall fills all stages.
//   Reset clears all stage valid bits and sets the map to hot.
//   When the receiver stalls, the output register holds its pixel and
//   earlier stages keep advancing into empty slots; sample.ready drops only
//   once all four stages hold a pixel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_to_rgb_colormap_assert.svh"

module scalar_to_rgb_colormap
    import s2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_data,
    s2rgb_in_if.sink         sample,
    s2rgb_out_if.source      pixel
);

    localparam int VW    = FRAC_BITS + 1;
    localparam int MAG_W = IN_W - 1;
    localparam int CMP_W = (VW > MAG_W) ? VW : MAG_W;
    localparam int K_W   = VW + Q_W;
    localparam int C_W   = VW + CH_W;
    localparam int B_W   = VW + RAD_W;
    localparam int VV_W  = 2 * VW;
    localparam int G_W   = VV_W + CH_W;
    localparam int A_W   = VW + CH_W + 1;
    localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    map_t map_sel_reg;

    logic en1, en2, en3, en4;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;

    // stage 1
    logic [MAG_W-1:0] mag;
    logic [VW-1:0]    v_clamp;
    logic [VW-1:0]    s1_v_reg;
    map_t             s1_map_reg;

    // stage 2
    logic [K_W-1:0]    p_k1, p_k2;
    logic [C_W-1:0]    p_gray, p_mr;
    logic [B_W-1:0]    p_b;
    logic [VV_W-1:0]   vv;
    logic [VW+1:0]     v4;
    logic [2:0]        seg_raw;
    logic [1:0]        seg;
    logic [VW-1:0]     t_frac;
    logic [Q_W-1:0]    s2_q_reg, s2_q2_reg;
    logic [CH_W-1:0]   s2_gray_reg, s2_mr_reg;
    logic [RAD_W-1:0]  s2_rad_reg;
    logic [VV_W-1:0]   s2_vv_reg;
    logic [1:0]        s2_seg_reg;
    logic [VW-1:0]     s2_t_reg;
    map_t              s2_map_reg;

    // stage 3
    logic              hot_lo, hot_hi;
    logic [Q_W-1:0]    d11, d17;
    logic [P11_W-1:0]  prod11;
    logic [P17_W-1:0]  prod17;
    logic [CH_W-1:0]   div11, div17;
    logic [CH_W-1:0]   hot_r, hot_g, hot_b;
    logic [VIR_IW-1:0] idx_a, idx_b;
    logic [A_W-1:0]    acc [3];
    logic [CH_W-1:0]   vir [3];
    logic [G_W-1:0]    p_mg;
    logic [CH_W-1:0]   s3_hot_r_reg, s3_hot_g_reg, s3_hot_b_reg;
    logic [CH_W-1:0]   s3_vir_reg [3];
    logic [CH_W-1:0]   s3_mg_reg, s3_gray_reg, s3_mr_reg;
    map_t              s3_map_reg;
    logic [ROOT_W-1:0] root;

    // stage 4
    logic [CH_W-1:0] red_next, green_next, blue_next;
    logic [CH_W-1:0] red_reg, green_reg, blue_reg;
    map_t            s4_map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_sel_reg <= MAP_HOT;
        end
        else if (cfg_wr_en)
        begin
            map_sel_reg <= map_t'(cfg_wr_data);
        end
    end

    assign en4          = !s4_vld_reg || pixel.ready;
    assign en3          = !s3_vld_reg || en4;
    assign en2          = !s2_vld_reg || en3;
    assign en1          = !s1_vld_reg || en2;
    assign sample.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_vld_reg <= sample.valid;
            end
            if (en2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (en3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (en4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
        end
    end

    // clamp to 0..ONE
    assign mag = sample.intensity[MAG_W-1:0];

    always_comb
    begin
        if (sample.intensity[IN_W-1])
        begin
            v_clamp = '0;
        end
        else if (CMP_W'(mag) > CMP_W'(ONE))
        begin
            v_clamp = ONE;
        end
        else
        begin
            v_clamp = VW'(mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_v_reg   <= v_clamp;
            s1_map_reg <= map_sel_reg;
        end
    end

    // products of the clamped value
    always_comb
    begin
        p_k1    = K_W'(s1_v_reg) * K_W'(HOT_K1);
        p_k2    = K_W'(s1_v_reg) * K_W'(HOT_K2);
        p_gray  = C_W'(s1_v_reg) * C_W'(GRAY_K);
        p_mr    = C_W'(s1_v_reg) * C_W'(MAG_R);
        p_b     = B_W'(s1_v_reg) * B_W'(MAG_B);
        vv      = VV_W'(s1_v_reg) * VV_W'(s1_v_reg);
        v4      = {s1_v_reg, 2'b00};
        seg_raw = v4[FRAC_BITS +: 3];
        seg     = seg_raw[2] ? 2'd3 : seg_raw[1:0];
        t_frac  = VW'(v4 - ((VW + 2)'(seg) << FRAC_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_q_reg    <= p_k1[FRAC_BITS +: Q_W];
            s2_q2_reg   <= p_k2[FRAC_BITS +: Q_W];
            s2_gray_reg <= p_gray[FRAC_BITS +: CH_W];
            s2_mr_reg   <= p_mr[FRAC_BITS +: CH_W];
            s2_rad_reg  <= p_b[FRAC_BITS +: RAD_W];
            s2_vv_reg   <= vv;
            s2_seg_reg  <= seg;
            s2_t_reg    <= t_frac;
            s2_map_reg  <= s1_map_reg;
        end
    end

    // hot ramps, viridis blend, magma green
    always_comb
    begin
        hot_lo = s2_q_reg < Q_W'(HOT_T33);
        hot_hi = s2_q2_reg >= Q_W'(HOT_T66);
        d11    = hot_lo ? s2_q_reg : s2_q_reg - Q_W'(HOT_T33);
        d17    = s2_q2_reg - Q_W'(HOT_T66);
        prod11 = P11_W'(d11) * P11_W'(RECIP11);
        prod17 = P17_W'(d17) * P17_W'(RECIP17);
        div11  = prod11[RECIP_SH +: CH_W];
        div17  = prod17[RECIP_SH +: CH_W];
        hot_r  = hot_lo ? div11 : CH_W'(GRAY_K);
        hot_g  = hot_lo ? '0 : (hot_hi ? CH_W'(GRAY_K) : div11);
        hot_b  = hot_hi ? div17 : '0;

        idx_a = {1'b0, s2_seg_reg};
        idx_b = idx_a + VIR_IW'(1);
        for (int c = 0; c < 3; c++)
        begin
            acc[c] = A_W'(VIR_PTS[idx_a][c]) * A_W'(ONE - s2_t_reg)
                   + A_W'(VIR_PTS[idx_b][c]) * A_W'(s2_t_reg);
            vir[c] = acc[c][FRAC_BITS +: CH_W];
        end

        p_mg = G_W'(s2_vv_reg) * G_W'(MAG_G);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_hot_r_reg <= hot_r;
            s3_hot_g_reg <= hot_g;
            s3_hot_b_reg <= hot_b;
            s3_vir_reg   <= vir;
            s3_mg_reg    <= p_mg[2*FRAC_BITS +: CH_W];
            s3_gray_reg  <= s2_gray_reg;
            s3_mr_reg    <= s2_mr_reg;
            s3_map_reg   <= s2_map_reg;
        end
    end

    s2rgb_isqrt u_isqrt (
        .clk      (clk),
        .en       (en3),
        .radicand (s2_rad_reg),
        .root     (root)
    );

    // select the map
    always_comb
    begin
        unique case (s3_map_reg)
            MAP_HOT:
            begin
                red_next   = s3_hot_r_reg;
                green_next = s3_hot_g_reg;
                blue_next  = s3_hot_b_reg;
            end
            MAP_VIRIDIS:
            begin
                red_next   = s3_vir_reg[0];
                green_next = s3_vir_reg[1];
                blue_next  = s3_vir_reg[2];
            end
            MAP_MAGMA:
            begin
                red_next   = s3_mr_reg;
                green_next = s3_mg_reg;
                blue_next  = root;
            end
            MAP_GRAY:
            begin
                red_next   = s3_gray_reg;
                green_next = s3_gray_reg;
                blue_next  = s3_gray_reg;
            end
            default:
            begin
                red_next   = s3_gray_reg;
                green_next = s3_gray_reg;
                blue_next  = s3_gray_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            s4_map_reg <= s3_map_reg;
        end
    end

    assign pixel.valid = s4_vld_reg;
    assign pixel.red   = red_reg;
    assign pixel.green = green_reg;
    assign pixel.blue  = blue_reg;

    `S2RGB_ASSERT_IMP(a_bubble_ready, !s1_vld_reg, sample.ready)
    `S2RGB_ASSERT_IMP(a_full_stall, s1_vld_reg && s2_vld_reg && s3_vld_reg && s4_vld_reg && !pixel.ready, !sample.ready)
    `S2RGB_ASSERT_NXT(a_take_sample, sample.valid && sample.ready, s1_vld_reg)
    `S2RGB_ASSERT_IMP(a_gray_equal, pixel.valid && s4_map_reg == MAP_GRAY, pixel.red == pixel.green && pixel.green == pixel.blue)
    `S2RGB_ASSERT_IMP(a_hot_order, pixel.valid && s4_map_reg == MAP_HOT, pixel.red == 8'hFF || (pixel.green == 8'h00 && pixel.blue == 8'h00))

endmodule

`default_nettype wire
